[design/kdm_pkg.sv]
// Package for the keypad debounce and digit multiplexer.
// Holds field widths, register indexes, reset values and the key result type.
// No dependencies.
`timescale 1ns / 1ps

package kdm_pkg;

  localparam int unsigned PinW     = 3;
  localparam int unsigned LineW    = 4;
  localparam int unsigned SegW     = 8;
  localparam int unsigned CodeW    = 5;
  localparam int unsigned TickW    = 10;
  localparam int unsigned HoldW    = 7;
  localparam int unsigned ScanW    = 6;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned NumDigits = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegDigit0  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDigit1  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDigit2  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDigit3  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBlink   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRepeat  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegInhibit = 3'd6;

  localparam logic [ScanW-1:0] RepeatReset  = 6'd21;
  localparam logic [ScanW-1:0] InhibitReset = 6'd6;

  localparam logic [PinW-1:0] PinsIdle = 3'h7;
  localparam logic [SegW-1:0] SegBlank = 8'hFF;

  // Blink mode bits.
  localparam int unsigned ModeBlankBit   = 0;
  localparam int unsigned ModeDotBlinkBit = 1;
  localparam int unsigned ModeRunDotBit  = 2;

  typedef struct packed {
    logic             event_hit;
    logic [CodeW-1:0] code;
  } key_result_t;

endpackage

[design/kdm_keyscan.sv]
// Key scanning and debounce: tick counter, per-scan key latch, hold and inhibit counting.
// Depends on kdm_pkg.
`timescale 1ns / 1ps

module kdm_keyscan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  logic [kdm_pkg::PinW-1:0]    key_pins_i,
  input  logic [kdm_pkg::ScanW-1:0]   repeat_scans_i,
  input  logic [kdm_pkg::ScanW-1:0]   inhibit_scans_i,
  output logic [kdm_pkg::TickW-1:0]   tick_next_o,
  output kdm_pkg::key_result_t        key_result_o
);
  import kdm_pkg::*;

  logic [TickW-1:0]        tick_q, tick_d;
  logic [CodeW-1:0]        scan_key_q, scan_key_d;
  logic [CodeW-1:0]        held_key_q, held_key_d;
  logic signed [HoldW-1:0] hold_q, hold_d;

  logic [1:0]              line;
  logic [CodeW-1:0]        pin_code;
  logic [CodeW-1:0]        scan_now;
  logic signed [HoldW:0]   hold_inc;
  logic signed [HoldW:0]   repeat_ext;
  key_result_t             result;

  assign line        = tick_q[1:0];
  assign tick_d      = tick_q + TickW'(1);
  assign tick_next_o = tick_d;

  always_comb begin
    pin_code = CodeW'(line) + CodeW'(1);
    if (!key_pins_i[1]) begin
      pin_code = pin_code + CodeW'(4);
    end
    if (!key_pins_i[2]) begin
      pin_code = pin_code + CodeW'(8);
    end
  end

  // The last line seen with a low pin wins within one scan.
  assign scan_now   = (key_pins_i != PinsIdle) ? pin_code : scan_key_q;
  assign hold_inc   = {hold_q[HoldW-1], hold_q} + (HoldW+1)'(1);
  assign repeat_ext = $signed({2'b00, repeat_scans_i});

  always_comb begin
    result     = '0;
    hold_d     = hold_q;
    held_key_d = held_key_q;
    scan_key_d = scan_now;
    if (line == 2'd3) begin
      if (!hold_q[HoldW-1]) begin
        if (scan_now != '0) begin
          if (held_key_q == '0) begin
            result.event_hit = 1'b1;
            result.code      = scan_now;
          end
          if (held_key_q == scan_now) begin
            hold_d = hold_inc[HoldW-1:0];
            if (hold_inc >= repeat_ext) begin
              result.event_hit = 1'b1;
              result.code      = scan_now;
              hold_d           = '0;
            end
          end
        end else if (held_key_q != '0) begin
          hold_d = -$signed({1'b0, inhibit_scans_i});
        end
      end else begin
        hold_d = hold_inc[HoldW-1:0];
      end
      held_key_d = scan_now;
      scan_key_d = '0;
    end
  end

  assign key_result_o = result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      scan_key_q <= '0;
      held_key_q <= '0;
      hold_q     <= '0;
    end else if (advance_i) begin
      tick_q     <= tick_d;
      scan_key_q <= scan_key_d;
      held_key_q <= held_key_d;
      hold_q     <= hold_d;
    end
  end

endmodule

[design/kdm_segmux.sv]
// Digit multiplexer: picks the active line and its segment pattern with blink modes.
// Depends on kdm_pkg.
`timescale 1ns / 1ps

module kdm_segmux (
  input  logic [kdm_pkg::TickW-1:0]                       tick_i,
  input  logic [kdm_pkg::NumDigits-1:0][kdm_pkg::SegW-1:0] digit_segs_i,
  input  logic [kdm_pkg::ModeW-1:0]                       blink_mode_i,
  output logic [kdm_pkg::LineW-1:0]                       line_drive_o,
  output logic [kdm_pkg::SegW-1:0]                        segment_drive_o
);
  import kdm_pkg::*;

  logic [1:0] line;
  logic       dot_on;

  assign line         = tick_i[1:0];
  assign line_drive_o = ~(LineW'(1) << line);

  assign dot_on = (blink_mode_i[ModeRunDotBit] && (tick_i[9:8] == line)) ||
                  (blink_mode_i[ModeDotBlinkBit] && tick_i[6]);

  always_comb begin
    if (blink_mode_i[ModeBlankBit] && tick_i[7]) begin
      segment_drive_o = SegBlank;
    end else begin
      segment_drive_o = digit_segs_i[line];
      if (dot_on) begin
        segment_drive_o[SegW-1] = 1'b0;
      end
    end
  end

endmodule

[design/keypad_debounce_and_digit_multiplexer.sv]
// Top level of the keypad debounce and digit multiplexer.
// Depends on kdm_pkg, kdm_keyscan and kdm_segmux.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o    key_pins_i
//   out      output     out_valid_o / out_stall_i  line_drive_o, segment_drive_o,
//                                                  key_event_o, key_code_o
//   cfg      input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// One item per cycle unless stalled: each item is one tick. Its result is
// written to the result register at the edge that accepts it and is offered
// from the next cycle on. The result register is the only stage; a new item
// is taken whenever that register is empty or being emptied in the same cycle.
// Reset clears the tick counter and the debounce state and returns the
// configuration to its reset values.
// A stall on the output holds the result and stalls the input.
`timescale 1ns / 1ps

module keypad_debounce_and_digit_multiplexer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [kdm_pkg::PinW-1:0]      key_pins_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [kdm_pkg::LineW-1:0]     line_drive_o,
  output logic [kdm_pkg::SegW-1:0]      segment_drive_o,
  output logic                          key_event_o,
  output logic [kdm_pkg::CodeW-1:0]     key_code_o,
  input  logic                          cfg_we_i,
  input  logic [kdm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [kdm_pkg::CfgDataW-1:0]  cfg_data_i
);
  import kdm_pkg::*;

  logic [NumDigits-1:0][SegW-1:0] digit_segs_q;
  logic [ModeW-1:0]               blink_mode_q;
  logic [ScanW-1:0]               repeat_scans_q;
  logic [ScanW-1:0]               inhibit_scans_q;

  logic                           in_accept;
  logic [TickW-1:0]               tick_next;
  key_result_t                    key_result;
  logic [LineW-1:0]               line_drive;
  logic [SegW-1:0]                segment_drive;

  logic                           out_valid_q;
  logic [LineW-1:0]               line_drive_q;
  logic [SegW-1:0]                segment_drive_q;
  key_result_t                    key_result_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_segs_q    <= '0;
      blink_mode_q    <= '0;
      repeat_scans_q  <= RepeatReset;
      inhibit_scans_q <= InhibitReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegDigit0:  digit_segs_q[0] <= cfg_data_i;
        RegDigit1:  digit_segs_q[1] <= cfg_data_i;
        RegDigit2:  digit_segs_q[2] <= cfg_data_i;
        RegDigit3:  digit_segs_q[3] <= cfg_data_i;
        RegBlink:   blink_mode_q    <= cfg_data_i[ModeW-1:0];
        RegRepeat:  repeat_scans_q  <= cfg_data_i[ScanW-1:0];
        RegInhibit: inhibit_scans_q <= cfg_data_i[ScanW-1:0];
        default:    ;
      endcase
    end
  end

  kdm_keyscan u_keyscan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (in_accept),
    .key_pins_i      (key_pins_i),
    .repeat_scans_i  (repeat_scans_q),
    .inhibit_scans_i (inhibit_scans_q),
    .tick_next_o     (tick_next),
    .key_result_o    (key_result)
  );

  kdm_segmux u_segmux (
    .tick_i          (tick_next),
    .digit_segs_i    (digit_segs_q),
    .blink_mode_i    (blink_mode_q),
    .line_drive_o    (line_drive),
    .segment_drive_o (segment_drive)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      line_drive_q    <= line_drive;
      segment_drive_q <= segment_drive;
      key_result_q    <= key_result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_drive_o    = line_drive_q;
  assign segment_drive_o = segment_drive_q;
  assign key_event_o     = key_result_q.event_hit;
  assign key_code_o      = key_result_q.code;

endmodule

[design/kdm_checker.sv]
// Port-level checks for the keypad debounce and digit multiplexer, with its bind.
// Depends on kdm_pkg and keypad_debounce_and_digit_multiplexer.
`timescale 1ns / 1ps

module kdm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [kdm_pkg::LineW-1:0]     line_drive_o,
  input logic [kdm_pkg::SegW-1:0]      segment_drive_o,
  input logic                          key_event_o,
  input logic [kdm_pkg::CodeW-1:0]     key_code_o
);
  import kdm_pkg::*;

  // Exactly one digit line is driven low.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones(line_drive_o) == LineW - 1)
    else $error("line_drive_o does not have exactly one low bit");

  // A key code appears with an event and only then.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (key_event_o == (key_code_o != '0)))
    else $error("key_code_o does not match key_event_o");

  // Events come only at the end of a scan, when the next line is line zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && key_event_o) |-> line_drive_o == 4'b1110)
    else $error("key event outside the end of a scan");

  // The input is never stalled while the result register is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty result register");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(line_drive_o) &&
      $stable(segment_drive_o) && $stable(key_code_o)))
    else $error("stalled result changed");

endmodule

bind keypad_debounce_and_digit_multiplexer kdm_checker u_kdm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .line_drive_o    (line_drive_o),
  .segment_drive_o (segment_drive_o),
  .key_event_o     (key_event_o),
  .key_code_o      (key_code_o)
);

[bench/testbench.sv]
// Testbench for keypad_debounce_and_digit_multiplexer: a directed table, then
// randomized key press sequences checked against a cycle model of the block.
// Depends on kdm_pkg and the design files.
`timescale 1ns / 1ps

module testbench;
  import kdm_pkg::*;

  localparam int ClkPeriod   = 4;
  localparam int ResetCycles = 5;
  localparam int PressCycles = 60;
  localparam int NumPhases   = 10;
  localparam int PhaseItems  = 150;

  typedef struct packed {
    logic [LineW-1:0] line;
    logic [SegW-1:0]  seg;
    key_result_t      key;
  } tick_result_t;

  typedef enum logic {RowItem, RowReg} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [PinW-1:0]     pins;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
    logic                typed;
    tick_result_t        want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [PinW-1:0]     key_pins_i = PinsIdle;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [LineW-1:0]    line_drive_o;
  logic [SegW-1:0]     segment_drive_o;
  logic                key_event_o;
  logic [CodeW-1:0]    key_code_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  keypad_debounce_and_digit_multiplexer dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .key_pins_i,
    .out_valid_o,
    .out_stall_i,
    .line_drive_o,
    .segment_drive_o,
    .key_event_o,
    .key_code_o,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Model of the block: configuration copy and debounce state.
  logic [SegW-1:0]  digit_seg [NumDigits];
  logic [ModeW-1:0] blink_sel;
  logic [ScanW-1:0] repeat_lim;
  logic [ScanW-1:0] inhibit_lim;
  logic [TickW-1:0] tick_ctr;
  logic [CodeW-1:0] scan_code;
  logic [CodeW-1:0] held_code;
  int               hold_ctr;

  tick_result_t tick_results_due [$];

  // Row currently offered by the driver; a typed row carries its own result.
  logic         row_typed = 1'b0;
  tick_result_t row_want = '0;

  int mismatches = 0;
  int ticks_checked = 0;
  int key_reports = 0;
  int reg_writes = 0;

  logic send_idle_on = 1'b1;
  logic recv_idle_on = 1'b1;
  logic press_req = 1'b0;
  int   stall_left = 0;

  // Key sequence generator state.
  logic [1:0]      drv_line = 2'd0;
  logic            gen_pressing = 1'b0;
  int              gen_scans_left = 0;
  logic [1:0]      gen_line = 2'd0;
  logic [PinW-1:0] gen_pins = PinsIdle;

  task automatic reset_model();
    for (int i = 0; i < NumDigits; i++) digit_seg[i] = '0;
    blink_sel   = '0;
    repeat_lim  = RepeatReset;
    inhibit_lim = InhibitReset;
    tick_ctr    = '0;
    scan_code   = '0;
    held_code   = '0;
    hold_ctr    = 0;
  endtask

  function automatic tick_result_t next_tick_result(input logic [PinW-1:0] pins);
    tick_result_t    r;
    logic [1:0]      ln;
    logic [CodeW-1:0] k;
    logic [SegW-1:0] seg;
    r  = '0;
    ln = tick_ctr[1:0];
    if (pins != PinsIdle) begin
      k = {3'b000, ln} + 5'd1;
      if (!pins[1]) k = k + 5'd4;
      if (!pins[2]) k = k + 5'd8;
      scan_code = k;
    end
    // The debounce decision is taken once per scan, on its last line.
    if (ln == 2'd3) begin
      if (hold_ctr >= 0) begin
        if (scan_code != '0) begin
          if (held_code == '0) begin
            r.key.event_hit = 1'b1;
            r.key.code      = scan_code;
          end
          if (held_code == scan_code) begin
            hold_ctr++;
            if (hold_ctr >= int'(repeat_lim)) begin
              r.key.event_hit = 1'b1;
              r.key.code      = scan_code;
              hold_ctr        = 0;
            end
          end
        end else if (held_code != '0) begin
          hold_ctr = -int'(inhibit_lim);
        end
      end else begin
        hold_ctr++;
      end
      held_code = scan_code;
      scan_code = '0;
    end
    tick_ctr = tick_ctr + 1'b1;
    ln = tick_ctr[1:0];
    if (blink_sel[ModeBlankBit] && tick_ctr[7]) begin
      seg = SegBlank;
    end else begin
      seg = digit_seg[ln];
      if ((blink_sel[ModeRunDotBit] && tick_ctr[9:8] == ln) ||
          (blink_sel[ModeDotBlinkBit] && tick_ctr[6])) seg[SegW-1] = 1'b0;
    end
    r.line = ~(4'b0001 << ln);
    r.seg  = seg;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    $display("mismatch at tick %0d, %s: got 0x%0h, expected 0x%0h",
             ticks_checked, field, got, want);
  endtask

  // Monitor: registers, accepted items and accepted results, all at the rising edge.
  always @(posedge clk_i) begin
    tick_result_t want;
    if (!rst_ni) begin
      reset_model();
      tick_results_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegDigit0, RegDigit1, RegDigit2, RegDigit3: digit_seg[cfg_index_i[1:0]] = cfg_data_i;
          RegBlink:   blink_sel   = cfg_data_i[ModeW-1:0];
          RegRepeat:  repeat_lim  = cfg_data_i[ScanW-1:0];
          RegInhibit: inhibit_lim = cfg_data_i[ScanW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        want = next_tick_result(key_pins_i);
        if (row_typed) want = row_want;
        tick_results_due.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        if (tick_results_due.size() == 0) begin
          report_mismatch("result with no item pending", 0, 0);
        end else begin
          want = tick_results_due.pop_front();
          if (line_drive_o !== want.line)
            report_mismatch("line_drive", int'(line_drive_o), int'(want.line));
          if (segment_drive_o !== want.seg)
            report_mismatch("segment_drive", int'(segment_drive_o), int'(want.seg));
          if (key_event_o !== want.key.event_hit)
            report_mismatch("key_event", int'(key_event_o), int'(want.key.event_hit));
          if (key_code_o !== want.key.code)
            report_mismatch("key_code", int'(key_code_o), int'(want.key.code));
          if (want.key.event_hit) key_reports++;
        end
        ticks_checked++;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else if (press_req) begin
        press_req   = 1'b0;
        stall_left  = PressCycles - 1;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = recv_idle_on && ($urandom_range(0, 99) < 29);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [PinW-1:0] pins, input logic typed,
                           input tick_result_t want);
    while (send_idle_on && $urandom_range(0, 99) < 29) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    key_pins_i = pins;
    row_typed  = typed;
    row_want   = want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    drv_line = drv_line + 1'b1;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (tick_results_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    reg_writes++;
  endtask

  // Mostly well-formed presses: one key held for some scans, then released,
  // with occasional key changes while held and a little pin noise.
  function automatic logic [PinW-1:0] pick_pins(input logic [1:0] ln);
    logic [PinW-1:0] p;
    if (ln == 2'd0) begin
      if (gen_scans_left <= 0) begin
        gen_pressing = !gen_pressing;
        if (gen_pressing) gen_scans_left = $urandom_range(1, int'(repeat_lim) + 3);
        else gen_scans_left = $urandom_range(1, int'(inhibit_lim) + 3);
        gen_line = 2'($urandom_range(0, 3));
        gen_pins = PinW'($urandom_range(0, 6));
      end else if (gen_pressing && $urandom_range(0, 99) < 10) begin
        gen_line = 2'($urandom_range(0, 3));
        gen_pins = PinW'($urandom_range(0, 6));
      end
      gen_scans_left--;
    end
    p = PinsIdle;
    if (gen_pressing && ln == gen_line) p = gen_pins;
    if ($urandom_range(0, 99) < 6) p = PinW'($urandom_range(0, 7));
    return p;
  endfunction

  function automatic stim_row_t item_row(input logic [PinW-1:0] pins);
    stim_row_t r;
    r      = '0;
    r.kind = RowItem;
    r.pins = pins;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [LineW-1:0] line,
                                          input logic [SegW-1:0] seg);
    stim_row_t r;
    r           = item_row(PinsIdle);
    r.typed     = 1'b1;
    r.want.line = line;
    r.want.seg  = seg;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [CfgIdxW-1:0] idx,
                                        input logic [CfgDataW-1:0] val);
    stim_row_t r;
    r      = '0;
    r.kind = RowReg;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  initial begin
    stim_row_t        dir_rows [$];
    stim_row_t        r;
    logic [SegW-1:0]  dig [NumDigits];
    logic [ModeW-1:0] bm;
    logic [ScanW-1:0] rep;
    logic [ScanW-1:0] inh;

    // After reset the first ticks step through lines 1, 2, 3, 0 with all-zero segment patterns.
    dir_rows.push_back(typed_row(4'hD, 8'h00));
    dir_rows.push_back(typed_row(4'hB, 8'h00));
    dir_rows.push_back(typed_row(4'h7, 8'h00));
    dir_rows.push_back(typed_row(4'hE, 8'h00));
    dir_rows.push_back(reg_row(RegDigit0, 8'hFF));
    dir_rows.push_back(reg_row(RegDigit1, 8'h00));
    dir_rows.push_back(reg_row(RegDigit2, 8'h80));
    dir_rows.push_back(reg_row(RegDigit3, 8'h7F));
    dir_rows.push_back(reg_row(RegBlink, 8'h00));
    dir_rows.push_back(reg_row(RegRepeat, 8'd1));
    dir_rows.push_back(reg_row(RegInhibit, 8'd0));
    // Two lines pressed in one scan: the later line wins.
    dir_rows.push_back(item_row(3'b000));
    dir_rows.push_back(item_row(PinsIdle));
    dir_rows.push_back(item_row(3'b110));
    dir_rows.push_back(item_row(PinsIdle));
    // The key changes without a release, twice.
    dir_rows.push_back(item_row(PinsIdle));
    dir_rows.push_back(item_row(3'b101));
    dir_rows.push_back(item_row(PinsIdle));
    dir_rows.push_back(item_row(PinsIdle));
    for (int s = 0; s < 2; s++) begin
      dir_rows.push_back(item_row(PinsIdle));
      dir_rows.push_back(item_row(PinsIdle));
      dir_rows.push_back(item_row(PinsIdle));
      dir_rows.push_back(item_row(3'b011));
    end
    // Release with no inhibit.
    for (int i = 0; i < 4; i++) dir_rows.push_back(item_row(PinsIdle));

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == RowReg) begin
        drain();
        write_reg(r.idx, r.val);
      end else begin
        send_item(r.pins, r.typed, r.want);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          foreach (dig[d]) dig[d] = 8'h00;
          bm  = 3'd7;
          rep = 6'd63;
          inh = 6'd63;
        end
        1: begin
          foreach (dig[d]) dig[d] = 8'hFF;
          bm  = 3'd0;
          rep = 6'd0;
          inh = 6'd0;
        end
        default: begin
          foreach (dig[d]) dig[d] = SegW'($urandom_range(0, 255));
          bm  = ModeW'($urandom_range(0, 7));
          rep = ($urandom_range(0, 3) == 0) ? ScanW'($urandom_range(0, 63))
                                            : ScanW'($urandom_range(0, 6));
          inh = ($urandom_range(0, 3) == 0) ? ScanW'($urandom_range(0, 63))
                                            : ScanW'($urandom_range(0, 6));
        end
      endcase
      drain();
      write_reg(RegDigit0, dig[0]);
      write_reg(RegDigit1, dig[1]);
      write_reg(RegDigit2, dig[2]);
      write_reg(RegDigit3, dig[3]);
      write_reg(RegBlink, CfgDataW'(bm));
      write_reg(RegRepeat, CfgDataW'(rep));
      write_reg(RegInhibit, CfgDataW'(inh));

      send_idle_on = (ph != 5) && (ph != 3);
      recv_idle_on = (ph != 5);
      // The receiver holds off for a long stretch while items keep coming.
      if (ph == 3) press_req = 1'b1;
      for (int n = 0; n < PhaseItems; n++) send_item(pick_pins(drv_line), 1'b0, '0);
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;

    drain();
    repeat (4) @(posedge clk_i);

    $display("checked %0d ticks, %0d key reports, %0d register writes",
             ticks_checked, key_reports, reg_writes);
    $display("covered press, repeat, key change, inhibit, blink modes and a long output stall");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[keypad_debounce_and_digit_multiplexer.f]
design/kdm_pkg.sv
design/kdm_keyscan.sv
design/kdm_segmux.sv
design/keypad_debounce_and_digit_multiplexer.sv
design/kdm_checker.sv
bench/testbench.sv
